// ----- rtl/symbol_table_lookup_define_defines.svh -----
// ----------------------------------------------------------------------------
// Symbol table assertion macros
// Shared concurrent assertion forms for the symbol table checker.
// ----------------------------------------------------------------------------
`ifndef SYMBOL_TABLE_LOOKUP_DEFINE_DEFINES_SVH
`define SYMBOL_TABLE_LOOKUP_DEFINE_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define STLD_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define STLD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/stld_pkg.sv -----
// ----------------------------------------------------------------------------
// Symbol table package
// Field widths, request codes and status codes shared by the design.
// ----------------------------------------------------------------------------
package stld_pkg;

  localparam int OP_W     = 2;
  localparam int FIELD_W  = 64;
  localparam int STATUS_W = 2;
  localparam int INDEX_W  = 6;

  typedef logic [OP_W-1:0]     op_t;
  typedef logic [STATUS_W-1:0] status_t;

  // Request codes; the unused code behaves as a plain lookup.
  localparam op_t OP_LOOKUP = 2'd0;
  localparam op_t OP_DEFINE = 2'd1;
  localparam op_t OP_STRICT = 2'd2;

  // Response status codes.
  localparam status_t ST_OK      = 2'd0;
  localparam status_t ST_DOUBLE  = 2'd1;
  localparam status_t ST_MISSING = 2'd2;
  localparam status_t ST_FULL    = 2'd3;

endpackage

// ----- rtl/stld_req_if.sv -----
// ----------------------------------------------------------------------------
// Symbol table request channel
// Valid/ready channel carrying one lookup, define or strict lookup request.
// ----------------------------------------------------------------------------
interface stld_req_if;
  logic                         valid;
  logic                         ready;
  stld_pkg::op_t                op;
  logic [stld_pkg::FIELD_W-1:0] key;
  logic [stld_pkg::FIELD_W-1:0] value;

  modport source (output valid, output op, output key, output value, input ready);
  modport sink   (input valid, input op, input key, input value, output ready);
endinterface

// ----- rtl/stld_rsp_if.sv -----
// ----------------------------------------------------------------------------
// Symbol table response channel
// Valid/ready channel carrying the outcome of one request.
// ----------------------------------------------------------------------------
interface stld_rsp_if;
  logic                         valid;
  logic                         ready;
  stld_pkg::status_t            status;
  logic [stld_pkg::INDEX_W-1:0] entry_index;
  logic [stld_pkg::FIELD_W-1:0] entry_value;
  logic                         entry_defined;
  logic                         created;

  modport source (output valid, output status, output entry_index, output entry_value,
                  output entry_defined, output created, input ready);
  modport sink   (input valid, input status, input entry_index, input entry_value,
                  input entry_defined, input created, output ready);
endinterface

// ----- rtl/stld_ram.sv -----
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module stld_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/symbol_table_lookup_define.sv -----
// ----------------------------------------------------------------------------
// Symbol table with forward references
// Search: linear, from acceptance of a request to its response register, with
//   one key memory read per used entry.
// Requests: one search at a time.
// Reset: synchronous; empties the table (fill count to zero), no memory sweep.
// ----------------------------------------------------------------------------
module symbol_table_lookup_define #(
  parameter int TABLE_ENTRIES = 64,
  parameter int KEY_BITS      = 64
) (
  input logic        clk,
  input logic        rst,
  stld_req_if.sink   req,
  stld_rsp_if.source rsp
);

  // Index into the stores, and a count wide enough to hold the table size.
  localparam int IDX_W = $clog2(TABLE_ENTRIES);
  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
  // The reported index is the low six bits of the position.
  localparam int POS_W = (IDX_W > stld_pkg::INDEX_W) ? IDX_W : stld_pkg::INDEX_W;
  // The value store holds the defined mark above the value.
  localparam int VAL_W = stld_pkg::FIELD_W + 1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SEARCH,
    S_MISS
  } state_t;

  state_t                         state;
  logic   [CNT_W-1:0]             used_count;
  logic   [IDX_W-1:0]             pos;
  stld_pkg::op_t                  op_q;
  logic   [KEY_BITS-1:0]          key_q;
  logic   [stld_pkg::FIELD_W-1:0] value_q;
  logic                           out_valid;

  // Memory ports.
  logic [IDX_W-1:0]    rd_addr;
  logic [KEY_BITS-1:0] key_rd;
  logic [VAL_W-1:0]    val_rd;
  logic                key_we;
  logic                val_we;
  logic [IDX_W-1:0]    wr_addr;
  logic [VAL_W-1:0]    val_wdata;

  // Decision signals.
  logic                           accept;
  logic                           out_free;
  logic                           hit;
  logic                           last;
  logic                           full;
  logic                           finish;
  logic                           append;
  stld_pkg::status_t              res_status;
  logic   [IDX_W-1:0]             res_pos;
  logic   [POS_W-1:0]             res_pos_ext;
  logic   [stld_pkg::FIELD_W-1:0] res_value;
  logic                           res_defined;
  logic                           res_created;

  // Keys live in one memory; the value and its defined mark in another. Both
  // are read at the same address, so a hit has its entry to hand at once.
  stld_ram #(
    .WIDTH (KEY_BITS),
    .DEPTH (TABLE_ENTRIES)
  ) u_key_ram (
    .clk   (clk),
    .we    (key_we),
    .waddr (wr_addr),
    .wdata (key_q),
    .raddr (rd_addr),
    .rdata (key_rd)
  );

  stld_ram #(
    .WIDTH (VAL_W),
    .DEPTH (TABLE_ENTRIES)
  ) u_val_ram (
    .clk   (clk),
    .we    (val_we),
    .waddr (wr_addr),
    .wdata (val_wdata),
    .raddr (rd_addr),
    .rdata (val_rd)
  );

  // The block takes a new transaction only when the search is idle. The
  // response register lets a finished result wait while the next request is
  // taken; a search that completes while that register is still occupied
  // holds its state until the register drains.
  assign req.ready = (state == S_IDLE);
  assign accept    = req.valid && req.ready;
  assign out_free  = !out_valid || rsp.ready;
  assign hit       = (key_rd == key_q);
  assign last      = ((CNT_W'(pos) + CNT_W'(1)) == used_count);
  assign full      = (used_count == CNT_W'(TABLE_ENTRIES));

  always_comb begin
    // By default the entry under examination is read again, so that its data
    // stays valid while a finished search waits for the response register.
    rd_addr     = pos;
    finish      = 1'b0;
    append      = 1'b0;
    key_we      = 1'b0;
    val_we      = 1'b0;
    wr_addr     = pos;
    val_wdata   = {1'b1, value_q};
    res_status  = stld_pkg::ST_OK;
    res_pos     = pos;
    res_value   = val_rd[stld_pkg::FIELD_W-1:0];
    res_defined = val_rd[stld_pkg::FIELD_W];
    res_created = 1'b0;

    unique case (state)
      S_IDLE: begin
        if (accept) begin
          rd_addr = '0;
        end
      end

      S_SEARCH: begin
        if (hit) begin
          finish = out_free;
          case (op_q)
            stld_pkg::OP_DEFINE: begin
              if (val_rd[stld_pkg::FIELD_W]) begin
                // Already defined: the entry keeps its old value.
                res_status = stld_pkg::ST_DOUBLE;
              end else begin
                val_we      = out_free;
                res_value   = value_q;
                res_defined = 1'b1;
              end
            end
            stld_pkg::OP_STRICT: begin
              if (!val_rd[stld_pkg::FIELD_W]) begin
                res_status = stld_pkg::ST_MISSING;
              end
            end
            default: begin
            end
          endcase
        end else if (!last) begin
          rd_addr = pos + IDX_W'(1);
        end
      end

      S_MISS: begin
        finish = out_free;
        if (full) begin
          // No room for a new entry: nothing changes and every field but the status is zero.
          res_status  = stld_pkg::ST_FULL;
          res_pos     = '0;
          res_value   = '0;
          res_defined = 1'b0;
        end else begin
          // Append at the end of the used entries. A define fills it in at
          // once; any other request leaves it expected with value zero.
          append      = out_free;
          key_we      = out_free;
          val_we      = out_free;
          wr_addr     = used_count[IDX_W-1:0];
          res_pos     = used_count[IDX_W-1:0];
          res_created = 1'b1;
          if (op_q == stld_pkg::OP_DEFINE) begin
            val_wdata   = {1'b1, value_q};
            res_value   = value_q;
            res_defined = 1'b1;
          end else begin
            val_wdata   = '0;
            res_value   = '0;
            res_defined = 1'b0;
            if (op_q == stld_pkg::OP_STRICT) begin
              res_status = stld_pkg::ST_MISSING;
            end
          end
        end
      end

      default: begin
      end
    endcase
  end

  assign res_pos_ext = POS_W'(res_pos);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      used_count <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (finish) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (accept) begin
            state <= (used_count == '0) ? S_MISS : S_SEARCH;
          end
        end
        S_SEARCH: begin
          if (hit) begin
            if (out_free) begin
              state <= S_IDLE;
            end
          end else if (last) begin
            state <= S_MISS;
          end
        end
        S_MISS: begin
          if (out_free) begin
            state <= S_IDLE;
          end
          if (append) begin
            used_count <= used_count + CNT_W'(1);
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end

    // Request and response payload registers need no reset.
    if (accept) begin
      op_q    <= req.op;
      key_q   <= req.key[KEY_BITS-1:0];
      value_q <= req.value;
      pos     <= '0;
    end else if (state == S_SEARCH && !hit && !last) begin
      pos <= pos + IDX_W'(1);
    end

    if (finish) begin
      rsp.status        <= res_status;
      rsp.entry_index   <= res_pos_ext[stld_pkg::INDEX_W-1:0];
      rsp.entry_value   <= res_value;
      rsp.entry_defined <= res_defined;
      rsp.created       <= res_created;
    end
  end

  assign rsp.valid = out_valid;

endmodule

// ----- rtl/stld_checker.sv -----
// ----------------------------------------------------------------------------
// Symbol table checker
// Port-level assertions on the request and response channels.
// ----------------------------------------------------------------------------
`include "symbol_table_lookup_define_defines.svh"

module stld_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         req_valid,
  input logic                         req_ready,
  input logic                         rsp_valid,
  input logic                         rsp_ready,
  input stld_pkg::status_t            rsp_status,
  input logic [stld_pkg::INDEX_W-1:0] rsp_entry_index,
  input logic [stld_pkg::FIELD_W-1:0] rsp_entry_value,
  input logic                         rsp_entry_defined,
  input logic                         rsp_created
);

  // A response waiting for the sink must stay and keep its status and value.
  `STLD_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_status) && $stable(rsp_entry_value), "response changed while stalled")

  // The search leaves the idle state on acceptance, so the block is busy in the cycle after a request.
  `STLD_ASSERT_NEXT(a_busy_after_req, req_valid && req_ready, !req_ready, "request taken while searching")

  // A full table reports nothing else.
  `STLD_ASSERT_SAME(a_full_zero, rsp_valid && rsp_status == stld_pkg::ST_FULL, !rsp_created && !rsp_entry_defined && rsp_entry_value == '0 && rsp_entry_index == '0, "table full response not cleared")

  // Status and defined mark must agree.
  `STLD_ASSERT_SAME(a_status_mark, rsp_valid && (rsp_status == stld_pkg::ST_DOUBLE || rsp_status == stld_pkg::ST_MISSING), rsp_entry_defined == (rsp_status == stld_pkg::ST_DOUBLE) && !(rsp_created && rsp_status == stld_pkg::ST_DOUBLE), "status disagrees with entry mark")

endmodule

bind symbol_table_lookup_define stld_checker u_stld_checker (
  .clk               (clk),
  .rst               (rst),
  .req_valid         (req.valid),
  .req_ready         (req.ready),
  .rsp_valid         (rsp.valid),
  .rsp_ready         (rsp.ready),
  .rsp_status        (rsp.status),
  .rsp_entry_index   (rsp.entry_index),
  .rsp_entry_value   (rsp.entry_value),
  .rsp_entry_defined (rsp.entry_defined),
  .rsp_created       (rsp.created)
);
